FILE: src/assert_macros.svh
// Assertion macros for the RTL files, included by pls_fifo
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define PLS_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset
`define PLS_ASSERT(label, prop, msg) \
    `PLS_ASSERT_RST(label, aclk, aresetn, prop, msg)

`endif

FILE: src/pls_pkg.sv
// Shared types and constants of the serpentine pixel to laser sample block
`default_nettype none
package pls_pkg;

    localparam logic [11:0] CH_MAX    = 12'd4095;
    localparam logic [11:0] MID_LEVEL = 12'd2048;
    localparam logic [12:0] DIM_LIMIT = 13'd4096;
    localparam logic [14:0] RECIP3    = 15'd21845;  // (2^16 - 1) / 3

    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_GREY = 2'd1;

    typedef enum logic [2:0] {
        CFG_COLOUR_MODE  = 3'd0,
        CFG_A_MINIMUM    = 3'd1,
        CFG_A_MAXIMUM    = 3'd2,
        CFG_B_MINIMUM    = 3'd3,
        CFG_B_MAXIMUM    = 3'd4,
        CFG_IMAGE_WIDTH  = 3'd5,
        CFG_IMAGE_HEIGHT = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  colour_mode;
        logic [11:0] a_minimum;
        logic [11:0] a_maximum;
        logic [11:0] b_minimum;
        logic [11:0] b_maximum;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } cfg_t;

    // One pixel after the front end: position known, colour still raw
    typedef struct packed {
        logic [11:0] x_position;
        logic [11:0] y_position;
        logic        last_of_image;
        logic [13:0] sum16;
        logic [11:0] red12;
        logic [11:0] green12;
        logic [11:0] blue12;
    } entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    typedef struct packed {
        logic [11:0] a_raw;
        logic [11:0] b_raw;
        logic        c_enable;
        logic        b_en;
        logic [11:0] x_position;
        logic [11:0] y_position;
        logic        last_of_image;
    } sel_t;

    typedef struct packed {
        logic [23:0] a_prod;
        logic [23:0] b_prod;
        logic        c_enable;
        logic        b_en;
        logic [11:0] x_position;
        logic [11:0] y_position;
        logic        last_of_image;
    } prod_t;

endpackage
`default_nettype wire

FILE: src/pls_front.sv
// Front end: scan position tracking and pixel classification
`default_nettype none
module pls_front
    import pls_pkg::*;
#(
    parameter int FIELD_SIZE = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_red,
    input  wire logic [15:0] s_green,
    input  wire logic [15:0] s_blue,
    input  wire q_stat_t     q_stat,
    output logic             push,
    output entry_t           push_data
);

    localparam int OW = $clog2(FIELD_SIZE + 1);
    localparam int DW = (OW > 13) ? OW : 13;
    localparam logic [DW-1:0] FIELD = DW'(FIELD_SIZE);

    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [12:0] w, h;
    logic [11:0] wm1, hm1;
    logic [DW-1:0] xdiff, ydiff;
    logic [11:0] xoff, yoff;
    logic [17:0] sum;
    logic        row_end, last;

    always_comb begin
        w = cfg.image_width;
        if (w == 13'd0) w = 13'd1;
        else if (w > DIM_LIMIT) w = DIM_LIMIT;
        h = cfg.image_height;
        if (h == 13'd0) h = 13'd1;
        else if (h > DIM_LIMIT) h = DIM_LIMIT;
    end

    assign wm1 = 12'(w - 13'd1);
    assign hm1 = 12'(h - 13'd1);

    // centring offset, zero when the image is at least as large as the field
    assign xdiff = (FIELD > DW'(w)) ? (FIELD - DW'(w)) : '0;
    assign ydiff = (FIELD > DW'(h)) ? (FIELD - DW'(h)) : '0;
    assign xoff  = xdiff[12:1];
    assign yoff  = ydiff[12:1];

    assign row_end = row_reg[0] ? (col_reg == 12'd0) : (col_reg >= wm1);
    assign last    = row_end && (row_reg >= hm1);

    assign sum = 18'(s_red) + 18'(s_green) + 18'(s_blue);

    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_data.x_position    = col_reg + xoff;
        push_data.y_position    = row_reg + yoff;
        push_data.last_of_image = last;
        push_data.sum16         = sum[17:4];
        push_data.red12         = s_red[15:4];
        push_data.green12       = s_green[15:4];
        push_data.blue12        = s_blue[15:4];
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            priority if (last) begin
                col_next = 12'd0;
                row_next = 12'd0;
            end else if (row_end) begin
                row_next = row_reg + 12'd1;
            end else if (row_reg[0]) begin
                col_next = col_reg - 12'd1;
            end else begin
                col_next = col_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 12'd0;
            row_reg <= 12'd0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/pls_fifo.sv
// Two-entry queue between the front end and the channel pipeline
`default_nettype none
`include "assert_macros.svh"
module pls_fifo
    import pls_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_data,
    input  wire logic   pop,
    output entry_t      pop_data,
    output q_stat_t     q_stat
);

    entry_t      mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign q_stat.full      = (count_reg == 2'd2);
    assign q_stat.not_empty = (count_reg != 2'd0);
    assign pop_data         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PLS_ASSERT(a_no_push_full, push |-> !q_stat.full, "push into full queue")
    `PLS_ASSERT(a_no_pop_empty, pop |-> q_stat.not_empty, "pop from empty queue")
    `PLS_ASSERT(a_ptr_count, (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg),
        "queue pointers disagree with count")

endmodule
`default_nettype wire

FILE: src/pls_back.sv
// Channel pipeline: average, mode select, scaling and output register
`default_nettype none
module pls_back
    import pls_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cfg_t    cfg,
    input  wire q_stat_t q_stat,
    input  wire entry_t  pop_data,
    output logic         pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output logic [11:0]  m_x_position,
    output logic [11:0]  m_y_position,
    output logic [11:0]  m_a_value,
    output logic [11:0]  m_b_value,
    output logic         m_c_enable,
    output logic         m_last_of_image
);

    // floor(p / 4095) for p up to 4095 * 4095: estimate is exact or one short
    function automatic logic [11:0] div4095(input logic [23:0] p);
        logic [24:0] t;
        logic [12:0] qe;
        logic [24:0] prod;
        logic [24:0] r;
        t    = 25'(p) + 25'(p[23:12]);
        qe   = t[24:12];
        prod = {qe, 12'd0} - 25'(qe);
        r    = 25'(p) - prod;
        if (r >= 25'd4095) qe = qe + 13'd1;
        return qe[11:0];
    endfunction

    sel_t  sel_reg, sel_next;
    prod_t prod_reg, prod_next;
    logic  va_reg, vb_reg, vo_reg;
    logic  ready_a, ready_b, ready_o;

    logic [11:0] x_reg, y_reg, a_reg, b_reg;
    logic        c_reg, last_reg;

    logic [28:0] recip;
    logic [12:0] q3;
    logic [13:0] rem3;
    logic [11:0] avg;
    logic [11:0] a_span, b_span;
    logic [11:0] a_out, b_out;

    assign ready_o = !vo_reg || m_ready;
    assign ready_b = !vb_reg || ready_o;
    assign ready_a = !va_reg || ready_b;
    assign pop     = q_stat.not_empty && ready_a;

    // average = floor(sum16 / 3) by reciprocal and one correction
    always_comb begin
        recip = 29'(pop_data.sum16) * 29'(RECIP3);
        q3    = recip[28:16];
        rem3  = pop_data.sum16 - 14'(q3) * 14'd3;
        avg   = (rem3 >= 14'd3) ? 12'(q3 + 13'd1) : q3[11:0];
    end

    always_comb begin
        sel_next.x_position    = pop_data.x_position;
        sel_next.y_position    = pop_data.y_position;
        sel_next.last_of_image = pop_data.last_of_image;
        sel_next.a_raw         = pop_data.red12;
        sel_next.b_raw         = pop_data.green12;
        sel_next.c_enable      = (pop_data.blue12 > MID_LEVEL);
        sel_next.b_en          = 1'b1;
        if (cfg.colour_mode == MODE_MONO) begin
            sel_next.a_raw    = (avg > MID_LEVEL) ? CH_MAX : 12'd0;
            sel_next.b_raw    = 12'd0;
            sel_next.c_enable = 1'b0;
            sel_next.b_en     = 1'b0;
        end else if (cfg.colour_mode == MODE_GREY) begin
            sel_next.a_raw    = avg;
            sel_next.b_raw    = 12'd0;
            sel_next.c_enable = 1'b0;
            sel_next.b_en     = 1'b0;
        end
    end

    assign a_span = (cfg.a_maximum >= cfg.a_minimum) ? (cfg.a_maximum - cfg.a_minimum) : 12'd0;
    assign b_span = (cfg.b_maximum >= cfg.b_minimum) ? (cfg.b_maximum - cfg.b_minimum) : 12'd0;

    always_comb begin
        prod_next.a_prod        = 24'(sel_reg.a_raw) * 24'(a_span);
        prod_next.b_prod        = 24'(sel_reg.b_raw) * 24'(b_span);
        prod_next.c_enable      = sel_reg.c_enable;
        prod_next.b_en          = sel_reg.b_en;
        prod_next.x_position    = sel_reg.x_position;
        prod_next.y_position    = sel_reg.y_position;
        prod_next.last_of_image = sel_reg.last_of_image;
    end

    assign a_out = div4095(prod_reg.a_prod) + cfg.a_minimum;
    assign b_out = prod_reg.b_en ? (div4095(prod_reg.b_prod) + cfg.b_minimum) : 12'd0;

    always_ff @(posedge aclk) begin
        if (ready_a) sel_reg <= sel_next;
        if (ready_b) prod_reg <= prod_next;
        if (ready_o) begin
            x_reg    <= prod_reg.x_position;
            y_reg    <= prod_reg.y_position;
            a_reg    <= a_out;
            b_reg    <= b_out;
            c_reg    <= prod_reg.c_enable;
            last_reg <= prod_reg.last_of_image;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (ready_a) va_reg <= pop;
            if (ready_b) vb_reg <= va_reg;
            if (ready_o) vo_reg <= vb_reg;
        end
    end

    assign m_valid         = vo_reg;
    assign m_x_position    = x_reg;
    assign m_y_position    = y_reg;
    assign m_a_value       = a_reg;
    assign m_b_value       = b_reg;
    assign m_c_enable      = c_reg;
    assign m_last_of_image = last_reg;

endmodule
`default_nettype wire

FILE: src/pixel_to_laser_sample_serpentine.sv
// Top level of the serpentine pixel to laser sample converter
//
// Pixels enter on the s_ channel (valid/ready), one 16-bit red, green and
// blue triple per transfer, in serpentine order: even rows left to right,
// odd rows right to left. Each pixel gives one sample on the m_ channel
// (valid/ready): centred x and y, scaled A and B values, the C enable and
// a flag on the last pixel of the image, after which the scan wraps.
// Registers are written through cfg_wr_en / cfg_index / cfg_wr_data, one
// per cycle; the user must write them only while no pixel is in flight,
// since the block itself does not enforce it. Throughput is one pixel per
// cycle while m_ready stays high, set by the three-stage channel pipeline
// behind a two-entry queue. When the receiver stalls, the pipeline and queue
// fill and then s_ready drops; nothing is lost. Synchronous reset (aresetn
// low) clears the scan position to column 0, row 0, empties the queue and
// pipeline, and restores register defaults; no clearing pass is needed.
`default_nettype none
module pixel_to_laser_sample_serpentine
    import pls_pkg::*;
#(
    parameter int FIELD_SIZE = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_red,
    input  wire logic [15:0] s_green,
    input  wire logic [15:0] s_blue,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_x_position,
    output logic [11:0]      m_y_position,
    output logic [11:0]      m_a_value,
    output logic [11:0]      m_b_value,
    output logic             m_c_enable,
    output logic             m_last_of_image
);

    cfg_t    cfg_reg, cfg_next;
    q_stat_t q_stat;
    entry_t  push_data, pop_data;
    logic    push, pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COLOUR_MODE:  cfg_next.colour_mode  = cfg_wr_data[1:0];
                CFG_A_MINIMUM:    cfg_next.a_minimum    = cfg_wr_data[11:0];
                CFG_A_MAXIMUM:    cfg_next.a_maximum    = cfg_wr_data[11:0];
                CFG_B_MINIMUM:    cfg_next.b_minimum    = cfg_wr_data[11:0];
                CFG_B_MAXIMUM:    cfg_next.b_maximum    = cfg_wr_data[11:0];
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_wr_data;
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.colour_mode  <= MODE_MONO;
            cfg_reg.a_minimum    <= 12'd0;
            cfg_reg.a_maximum    <= CH_MAX;
            cfg_reg.b_minimum    <= 12'd0;
            cfg_reg.b_maximum    <= CH_MAX;
            cfg_reg.image_width  <= DIM_LIMIT;
            cfg_reg.image_height <= DIM_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pls_front #(
        .FIELD_SIZE(FIELD_SIZE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_red     (s_red),
        .s_green   (s_green),
        .s_blue    (s_blue),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    pls_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    pls_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_stat          (q_stat),
        .pop_data        (pop_data),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_position    (m_x_position),
        .m_y_position    (m_y_position),
        .m_a_value       (m_a_value),
        .m_b_value       (m_b_value),
        .m_c_enable      (m_c_enable),
        .m_last_of_image (m_last_of_image)
    );

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the serpentine pixel to laser sample converter
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pls_pkg::*;

    localparam int FIELD = 4096;
    localparam logic [1:0] MODE_RGB = 2'd2;
    localparam logic [1:0] MODE_RGB_ALIAS = 2'd3;   // decodes as rgb
    localparam int RANDOM_PIXELS = 1700;
    localparam int SLACK_CYCLES = 12;

    typedef struct packed {
        logic [11:0] x_position;
        logic [11:0] y_position;
        logic [11:0] a_value;
        logic [11:0] b_value;
        logic        c_enable;
        logic        last_of_image;
    } laser_sample_t;

    class sample_scoreboard;
        logic [1:0]  colour_mode;
        logic [11:0] a_min, a_max, b_min, b_max;
        logic [12:0] width, height;
        logic [11:0] column, row;
        laser_sample_t expected_q[$];
        int mismatches;

        function new();
            colour_mode = MODE_MONO;
            a_min = 0;
            a_max = CH_MAX;
            b_min = 0;
            b_max = CH_MAX;
            width = DIM_LIMIT;
            height = DIM_LIMIT;
            column = 0;
            row = 0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [12:0] data);
            case (idx)
                CFG_COLOUR_MODE:  colour_mode = data[1:0];
                CFG_A_MINIMUM:    a_min = data[11:0];
                CFG_A_MAXIMUM:    a_max = data[11:0];
                CFG_B_MINIMUM:    b_min = data[11:0];
                CFG_B_MAXIMUM:    b_max = data[11:0];
                CFG_IMAGE_WIDTH:  width = data;
                CFG_IMAGE_HEIGHT: height = data;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(logic [12:0] d);
            if (d == 0) return 1;
            if (d > DIM_LIMIT) return DIM_LIMIT;
            return d;
        endfunction

        function int unsigned centre_offset(int unsigned d);
            return (FIELD > d) ? (FIELD - d) / 2 : 0;
        endfunction

        // min above max collapses the span, so the channel sits at its minimum
        function logic [11:0] scale(int unsigned v, logic [11:0] lo, logic [11:0] hi);
            int unsigned span;
            span = (hi >= lo) ? hi - lo : 0;
            return 12'((v * span) / CH_MAX + lo);
        endfunction

        function void note_pixel(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
            int unsigned r, g, b, w, h, avg, a_raw;
            logic row_end;
            laser_sample_t s;
            r = red;
            g = green;
            b = blue;
            w = clamp_dim(width);
            h = clamp_dim(height);
            avg = ((r + g + b) / 3) >> 4;
            s = '0;
            case (colour_mode)
                MODE_MONO: begin
                    a_raw = (avg > MID_LEVEL) ? CH_MAX : 0;
                    s.a_value = scale(a_raw, a_min, a_max);
                end
                MODE_GREY: s.a_value = scale(avg, a_min, a_max);
                default: begin
                    s.a_value = scale(r >> 4, a_min, a_max);
                    s.b_value = scale(g >> 4, b_min, b_max);
                    s.c_enable = ((b >> 4) > MID_LEVEL);
                end
            endcase
            // odd rows run right to left; a shrunk width ends an even row early
            if (row[0])
                row_end = (column == 0);
            else
                row_end = (column >= w - 1);
            s.last_of_image = row_end && (row >= h - 1);
            s.x_position = 12'(column + centre_offset(w));
            s.y_position = 12'(row + centre_offset(h));
            if (s.last_of_image) begin
                column = 0;
                row = 0;
            end else if (row_end) begin
                row = row + 1;
            end else if (row[0]) begin
                column = column - 1;
            end else begin
                column = column + 1;
            end
            expected_q.push_back(s);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_sample(laser_sample_t got);
            laser_sample_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: sample transfer, expected none, actual x %0d y %0d",
                         $time, got.x_position, got.y_position);
                return;
            end
            want = expected_q.pop_front();
            compare_field("x_position", want.x_position, got.x_position);
            compare_field("y_position", want.y_position, got.y_position);
            compare_field("a_value", want.a_value, got.a_value);
            compare_field("b_value", want.b_value, got.b_value);
            compare_field("c_enable", want.c_enable, got.c_enable);
            compare_field("last_of_image", want.last_of_image, got.last_of_image);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_red = '0;
    logic [15:0] s_green = '0;
    logic [15:0] s_blue = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_x_position, m_y_position, m_a_value, m_b_value;
    logic        m_c_enable, m_last_of_image;

    int idle_pct = 32;
    sample_scoreboard scoreboard;

    pixel_to_laser_sample_serpentine DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_x_position   (m_x_position),
        .m_y_position   (m_y_position),
        .m_a_value      (m_a_value),
        .m_b_value      (m_b_value),
        .m_c_enable     (m_c_enable),
        .m_last_of_image(m_last_of_image)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sample sink: check each transfer, then stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scoreboard.check_sample('{m_x_position, m_y_position, m_a_value,
                                      m_b_value, m_c_enable, m_last_of_image});
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic send_pixel(input logic [15:0] red, input logic [15:0] green,
                              input logic [15:0] blue);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red <= red;
        s_green <= green;
        s_blue <= blue;
        do @(posedge aclk); while (!s_ready);
        scoreboard.note_pixel(red, green, blue);
    endtask

    function automatic logic [15:0] rand_level();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1: return 16'($urandom_range(32832, 32720));   // around the midpoint
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_pixels(input int count);
        logic [15:0] level;
        repeat (count) begin
            if ($urandom_range(3) == 0) begin
                level = rand_level();
                send_pixel(level, level, level);
            end else begin
                send_pixel(rand_level(), rand_level(), rand_level());
            end
        end
    endtask

    // wait until every pixel sent so far has come back out
    task automatic drain();
        s_valid <= 1'b0;
        while (scoreboard.expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [12:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        scoreboard.write_reg(idx, data);
    endtask

    task automatic configure(input logic [12:0] mode, input logic [12:0] a_lo,
                             input logic [12:0] a_hi, input logic [12:0] b_lo,
                             input logic [12:0] b_hi, input logic [12:0] w,
                             input logic [12:0] h);
        write_reg(CFG_COLOUR_MODE, mode);
        write_reg(CFG_A_MINIMUM, a_lo);
        write_reg(CFG_A_MAXIMUM, a_hi);
        write_reg(CFG_B_MINIMUM, b_lo);
        write_reg(CFG_B_MAXIMUM, b_hi);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [12:0] rand_dim();
        case ($urandom_range(9))
            0: return 13'd0;
            1: return 13'($urandom);
            2: return DIM_LIMIT;
            default: return 13'($urandom_range(8, 1));
        endcase
    endfunction

    function automatic logic [12:0] rand_limit();
        case ($urandom_range(5))
            0: return 13'd0;
            1: return 13'(CH_MAX);
            2: return 13'($urandom);
            default: return 13'($urandom_range(4095));
        endcase
    endfunction

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int random_sent;
        int phase;
        int count;
        logic [12:0] a_lo, a_hi, b_lo, b_hi, tmp;

        scoreboard = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: monochrome, full scale, 4096 x 4096
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h8000, 16'h8000);     // average exactly at threshold
        send_pixel(16'h8010, 16'h8010, 16'h8010);     // one step above
        drain();

        // greyscale, sizes out of range on both ends
        configure(MODE_GREY, 13'd100, 13'd4000, 13'd0, 13'd4095, 13'd0, 13'h1FFF);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h1234, 16'h5678, 16'h9ABC);
        drain();

        // rgb with A minimum above maximum, small image
        configure(MODE_RGB, 13'd3000, 13'd1000, 13'd0, 13'd4095, 13'd3, 13'd2);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h8000);
        send_pixel(16'h0000, 16'h0000, 16'h8010);
        send_pixel(16'h8000, 16'h0001, 16'hFFFF);
        drain();

        // mode three, upper data bits set on a 12-bit register
        configure(MODE_RGB_ALIAS, 13'd0, 13'h1FFF, 13'd4095, 13'd4095, 13'd3, 13'd2);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h7FFF, 16'h8000, 16'h8010);
        send_pixel(16'hFFF0, 16'h000F, 16'h0010);
        drain();

        // size shrunk in the middle of the scan
        configure(MODE_MONO, 13'd0, 13'd0, 13'd0, 13'd4095, 13'd2, 13'd1);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
        drain();

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_PIXELS) begin
            drain();
            a_lo = rand_limit();
            a_hi = rand_limit();
            b_lo = rand_limit();
            b_hi = rand_limit();
            // keep most spans ordered; the rest exercise a collapsed span
            if ($urandom_range(3) != 0 && a_lo[11:0] > a_hi[11:0]) begin
                tmp = a_lo;
                a_lo = a_hi;
                a_hi = tmp;
            end
            if ($urandom_range(3) != 0 && b_lo[11:0] > b_hi[11:0]) begin
                tmp = b_lo;
                b_lo = b_hi;
                b_hi = tmp;
            end
            configure($urandom_range(1) ? 13'($urandom) : 13'($urandom_range(3)),
                      a_lo, a_hi, b_lo, b_hi, rand_dim(), rand_dim());
            idle_pct = (phase == 6) ? 0 : 32;
            count = (phase == 6) ? 200 : $urandom_range(60, 15);
            run_pixels(count);
            random_sent += count;
            phase++;
        end

        drain();
        repeat (SLACK_CYCLES) @(posedge aclk);
        if (scoreboard.mismatches == 0 && scoreboard.expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
